FILE: design/nfls_pkg.sv
// nfls_pkg: types, constants and codes shared by the nearest-four light select block.
// No dependencies; imported by every module in the design folder.
package nfls_pkg;

    localparam int KEEP_SLOTS = 4;
    localparam int CNT_W      = $clog2(KEEP_SLOTS + 1);
    localparam int POS_W      = 24;
    localparam int DIFF_W     = POS_W + 1;
    localparam int DIST_W     = 50;
    localparam int ID_W       = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int REPORT_IDS = 4;

    localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_Z = 2'd2;

    localparam logic [1:0] STAT_KEPT    = 2'd0;
    localparam logic [1:0] STAT_DROPPED = 2'd1;
    localparam logic [1:0] STAT_SKIPPED = 2'd2;
    localparam logic [1:0] STAT_CLEARED = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SUM,
        ST_INS,
        ST_RES
    } t_state;

    typedef struct packed {
        logic                    action;
        logic                    visible;
        logic                    is_point;
        logic [ID_W-1:0]         light_id;
        logic signed [POS_W-1:0] pos_x;
        logic signed [POS_W-1:0] pos_y;
        logic signed [POS_W-1:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic [1:0]      status;
        logic [1:0]      slot;
        logic [2:0]      count;
        logic [ID_W-1:0] kept_id_0;
        logic [ID_W-1:0] kept_id_1;
        logic [ID_W-1:0] kept_id_2;
        logic [ID_W-1:0] kept_id_3;
    } t_out_item;

    typedef struct packed {
        logic [DIST_W-1:0] dist_sq;
        logic [ID_W-1:0]   id;
    } t_entry;

    typedef struct packed {
        logic              load_en;
        logic [DIST_W-1:0] dist_sq;
        logic [ID_W-1:0]   id;
    } t_cell_ctl;

endpackage

FILE: design/nearest_four_light_select_top.sv
// nearest_four_light_select_top: top level of the nearest-four light select block.
// Depends on nfls_pkg, nfls_sqdist and nfls_cell.
//
// Usage:
//   Configuration: write center_x, center_y, center_z (index 0, 1, 2) on the
//   cfg channel while the block is idle; o_cfg_ready is always high and an
//   index of 3 is ignored.
//   Input: one item per transfer on i_in_valid/o_in_ready. A visible point
//   offer is insertion-sorted by squared distance to the centre into KEEP_SLOTS
//   cells unless the row is full and it is no closer than the last one kept; a clear empties the row.
//   Output: one result per item on o_out_valid/i_out_ready, held in an output
//   register so the next item is taken while a result still waits.
//   Sequence: each item is squared at the transfer edge, then passes the sum,
//   insert and report steps before its result is registered; the block then
//   returns to the idle step, where it takes the next transfer. The four-step
//   sequencer handles one item at a time.
//   Stall: if the output register is still full, the item waits in the report
//   step and o_in_ready stays low until the result is taken.
//   Reset: synchronous, active low; empties the list, zeroes the centre,
//   drops any pending result. No clearing pass is needed.
module nearest_four_light_select_top (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [nfls_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [nfls_pkg::POS_W-1:0]     i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  nfls_pkg::t_in_item             i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output nfls_pkg::t_out_item            o_out_item
);
    import nfls_pkg::*;

    t_state r_state;
    t_state n_state;

    logic signed [POS_W-1:0] r_center_x;
    logic signed [POS_W-1:0] r_center_y;
    logic signed [POS_W-1:0] r_center_z;

    logic            r_action;
    logic            r_ok;
    logic [ID_W-1:0] r_id;

    logic [DIST_W-1:0] w_sq_x;
    logic [DIST_W-1:0] w_sq_y;
    logic [DIST_W-1:0] w_sq_z;
    logic [DIST_W-1:0] r_dist;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic [1:0]       r_status;
    logic [1:0]       n_status;
    logic [1:0]       r_slot;
    logic [1:0]       n_slot;

    logic            r_out_valid;
    t_out_item       r_out_item;
    t_out_item       w_result;

    logic             w_accept;
    logic             w_offer;
    logic             w_full;
    logic             w_closer;
    logic             w_insert;
    logic [CNT_W-1:0] w_pos;
    logic             w_sorted;

    t_cell_ctl            w_ctl;
    logic [KEEP_SLOTS-1:0] w_valid;
    logic [KEEP_SLOTS-1:0] w_lt;
    logic [KEEP_SLOTS-1:0] w_prev_lt;
    t_entry               w_entry [KEEP_SLOTS];
    t_entry               w_prev  [KEEP_SLOTS];
    logic [ID_W-1:0]      w_ids   [REPORT_IDS];

    assign o_cfg_ready = 1'b1;
    assign o_in_ready  = (r_state == ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_center_x <= '0;
            r_center_y <= '0;
            r_center_z <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_CENTER_X: r_center_x <= i_cfg_data;
                REG_CENTER_Y: r_center_y <= i_cfg_data;
                REG_CENTER_Z: r_center_z <= i_cfg_data;
                default: ;
            endcase
        end
    end

    nfls_sqdist u_sq_x (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_pos    (i_in_item.pos_x),
        .i_center (r_center_x),
        .o_sq     (w_sq_x)
    );

    nfls_sqdist u_sq_y (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_pos    (i_in_item.pos_y),
        .i_center (r_center_y),
        .o_sq     (w_sq_y)
    );

    nfls_sqdist u_sq_z (
        .i_clk    (i_clk),
        .i_en     (w_accept),
        .i_pos    (i_in_item.pos_z),
        .i_center (r_center_z),
        .o_sq     (w_sq_z)
    );

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_action <= i_in_item.action;
            r_ok     <= i_in_item.visible && i_in_item.is_point;
            r_id     <= i_in_item.light_id;
        end
        if (r_state == ST_SUM) begin
            r_dist <= w_sq_x + w_sq_y + w_sq_z;
        end
    end

    assign w_offer  = !r_action && r_ok;
    assign w_full   = (r_count == CNT_W'(KEEP_SLOTS));
    assign w_closer = (r_dist < w_entry[KEEP_SLOTS-1].dist_sq);
    assign w_insert = w_offer && !(w_full && !w_closer);

    assign w_ctl.load_en = (r_state == ST_INS) && w_insert;
    assign w_ctl.dist_sq = r_dist;
    assign w_ctl.id      = r_id;

    for (genvar j = 0; j < KEEP_SLOTS; j++) begin : g_cell
        assign w_valid[j] = (CNT_W'(j) < r_count);
        if (j == 0) begin : g_head
            assign w_prev_lt[j] = 1'b1;
            assign w_prev[j]    = w_entry[j];
        end else begin : g_link
            assign w_prev_lt[j] = w_lt[j-1];
            assign w_prev[j]    = w_entry[j-1];
        end
        nfls_cell u_cell (
            .i_clk     (i_clk),
            .i_ctl     (w_ctl),
            .i_valid   (w_valid[j]),
            .i_prev_lt (w_prev_lt[j]),
            .i_prev    (w_prev[j]),
            .o_lt      (w_lt[j]),
            .o_entry   (w_entry[j])
        );
    end

    always_comb begin
        w_pos = '0;
        for (int j = 0; j < KEEP_SLOTS; j++) begin
            w_pos = w_pos + CNT_W'(w_lt[j]);
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = r_status;
        n_slot   = r_slot;
        if (r_state == ST_INS) begin
            n_slot = '0;
            if (r_action) begin
                n_count  = '0;
                n_status = STAT_CLEARED;
            end else if (!r_ok) begin
                n_status = STAT_SKIPPED;
            end else if (!w_insert) begin
                n_status = STAT_DROPPED;
            end else begin
                n_status = STAT_KEPT;
                n_slot   = w_pos[1:0];
                if (!w_full) begin
                    n_count = r_count + CNT_W'(1);
                end
            end
        end
    end

    for (genvar k = 0; k < REPORT_IDS; k++) begin : g_ids
        if (k < KEEP_SLOTS) begin : g_live
            assign w_ids[k] = (CNT_W'(k) < r_count) ? w_entry[k].id : '0;
        end else begin : g_none
            assign w_ids[k] = '0;
        end
    end

    always_comb begin
        w_result.status    = r_status;
        w_result.slot      = r_slot;
        w_result.count     = 3'(r_count);
        w_result.kept_id_0 = w_ids[0];
        w_result.kept_id_1 = w_ids[1];
        w_result.kept_id_2 = w_ids[2];
        w_result.kept_id_3 = w_ids[3];
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = ST_SUM;
                end
            end
            ST_SUM: n_state = ST_INS;
            ST_INS: n_state = ST_RES;
            ST_RES: begin
                if (!r_out_valid || i_out_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            if (r_state == ST_RES && (!r_out_valid || i_out_ready)) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= n_status;
        r_slot   <= n_slot;
        if (r_state == ST_RES && (!r_out_valid || i_out_ready)) begin
            r_out_item <= w_result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        w_sorted = 1'b1;
        for (int j = 1; j < KEEP_SLOTS; j++) begin
            if (w_valid[j] && (w_entry[j-1].dist_sq > w_entry[j].dist_sq)) begin
                w_sorted = 1'b0;
            end
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(KEEP_SLOTS))
        else $error("kept count beyond slot count");

    a_count_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != ST_INS) |=> $stable(r_count))
        else $error("kept count changed outside the insert step");

    a_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> w_sorted)
        else $error("kept list out of order");

    a_slot_in_list: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_item.status == STAT_KEPT) |->
            ({1'b0, o_out_item.slot} < o_out_item.count || KEEP_SLOTS > REPORT_IDS))
        else $error("reported slot beyond kept count");

endmodule

FILE: design/nfls_sqdist.sv
// nfls_sqdist: one axis of the squared distance, difference and square, registered.
// Depends on nfls_pkg.
module nfls_sqdist (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic signed [nfls_pkg::POS_W-1:0] i_pos,
    input  logic signed [nfls_pkg::POS_W-1:0] i_center,
    output logic [nfls_pkg::DIST_W-1:0]      o_sq
);
    import nfls_pkg::*;

    logic signed [DIFF_W-1:0] w_diff;
    logic [DIFF_W-1:0]        w_mag;
    logic [DIST_W-1:0]        r_sq;

    assign w_diff = DIFF_W'(i_pos) - DIFF_W'(i_center);
    assign w_mag  = w_diff[DIFF_W-1] ? DIFF_W'(-w_diff) : DIFF_W'(w_diff);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sq <= DIST_W'(w_mag * w_mag);
        end
    end

    assign o_sq = r_sq;

endmodule

FILE: design/nfls_cell.sv
// nfls_cell: one slot of the sorted list; holds, takes the candidate or takes its neighbor.
// Depends on nfls_pkg.
module nfls_cell (
    input  logic                i_clk,
    input  nfls_pkg::t_cell_ctl i_ctl,
    input  logic                i_valid,
    input  logic                i_prev_lt,
    input  nfls_pkg::t_entry    i_prev,
    output logic                o_lt,
    output nfls_pkg::t_entry    o_entry
);
    import nfls_pkg::*;

    t_entry r_entry;
    t_entry n_entry;

    assign o_lt = i_valid && (r_entry.dist_sq < i_ctl.dist_sq);

    always_comb begin
        n_entry = r_entry;
        if (i_ctl.load_en && !o_lt) begin
            if (i_prev_lt) begin
                n_entry.dist_sq = i_ctl.dist_sq;
                n_entry.id      = i_ctl.id;
            end else begin
                n_entry = i_prev;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_entry <= n_entry;
    end

    assign o_entry = r_entry;

endmodule
